[hdl/chained_hash_map_macros.svh]
// ----------------------------------------------------------------------------
// Chained hash map assertion macros
// Shared concurrent assertion forms for the checker of the hash map.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_MACROS_SVH
`define CHAINED_HASH_MAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("chained hash map assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CHM_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("chained hash map assertion failed");

`endif

[hdl/chm_pkg.sv]
// ----------------------------------------------------------------------------
// Chained hash map package
// Field widths, default sizes, command and status codes.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int KEY_W        = 64;
    localparam int VALUE_W      = 64;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 11;

    localparam int BUCKETS_DEF  = 256;
    localparam int POOL_DEF     = 1024;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd4;

endpackage

[hdl/chm_ram.sv]
// ----------------------------------------------------------------------------
// Chained hash map RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/chained_hash_map.sv]
// ----------------------------------------------------------------------------
// Chained hash map
// Key-value map with separate chaining over a bump-allocated entry pool.
//
//   Channel   Direction  Ports                                 Request
//   s_        in         s_command, s_key, s_value             one operation
//   m_        out        m_status, m_read_value,               one result
//                        m_entry_count, m_is_empty
//
// A request goes from acceptance through S_HEAD, which reads the bucket head,
// S_HEADCHK, S_WALK for each chain entry read, and S_RESULT; an insert behind
// an existing chain adds S_LINK. The walk is set by the single read port of
// the entry RAM, one entry a cycle. When BUCKETS is not a power of two, S_HASH
// first reduces the bucket one key byte a cycle. After reset the bucket heads
// are cleared in turn while no request is taken. A waiting result does not
// keep the next request from being accepted.
// ----------------------------------------------------------------------------
module chained_hash_map #(
    parameter int BUCKETS      = chm_pkg::BUCKETS_DEF,
    parameter int POOL_ENTRIES = chm_pkg::POOL_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [chm_pkg::KEY_W-1:0]     s_key,
    input  logic [chm_pkg::VALUE_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [chm_pkg::STATUS_W-1:0]  m_status,
    output logic [chm_pkg::VALUE_W-1:0]   m_read_value,
    output logic [chm_pkg::COUNT_W-1:0]   m_entry_count,
    output logic                          m_is_empty
);

    import chm_pkg::*;

    localparam int PTR_W   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(POOL_ENTRIES + 1);
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int HEAD_W  = PTR_W + 1;
    localparam int ENTRY_W = KEY_W + VALUE_W + PTR_W + 1;
    localparam bit BUCKET_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_HASH    = 3'd2;
    localparam logic [2:0] S_HEAD    = 3'd3;
    localparam logic [2:0] S_HEADCHK = 3'd4;
    localparam logic [2:0] S_WALK    = 3'd5;
    localparam logic [2:0] S_LINK    = 3'd6;
    localparam logic [2:0] S_RESULT  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [BKT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [2:0]         hash_cnt_reg, hash_cnt_next;
    logic               m_valid_reg, m_valid_next;

    logic               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [BKT_W-1:0]   bucket_reg, bucket_next;
    logic [PTR_W-1:0]   cur_reg, cur_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0] rv_reg, rv_next;

    logic [STATUS_W-1:0] m_status_reg;
    logic [VALUE_W-1:0]  m_read_value_reg;
    logic [COUNT_W-1:0]  m_entry_count_reg;
    logic                m_is_empty_reg;

    logic               head_we, head_re;
    logic [BKT_W-1:0]   head_waddr, head_raddr;
    logic [HEAD_W-1:0]  head_wdata, head_rdata;
    logic               entry_we, entry_re;
    logic [PTR_W-1:0]   entry_waddr, entry_raddr;
    logic [ENTRY_W-1:0] entry_wdata, entry_rdata;

    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_value;
    logic               rd_link_valid;
    logic [PTR_W-1:0]   rd_link;
    logic               head_valid;
    logic [PTR_W-1:0]   head_ptr;

    logic [BKT_W-1:0]   reduce_r;
    logic [BKT_W:0]     reduce_t;
    logic [7:0]         key_byte;
    logic [PTR_W-1:0]   new_idx;
    logic               pool_full;
    logic               resolve;
    logic               found;
    logic               chain_empty;
    logic               out_load;

    chm_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (BUCKETS)
    ) u_head_ram (
        .clk   (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    chm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_ENTRIES)
    ) u_entry_ram (
        .clk   (aclk),
        .we    (entry_we),
        .waddr (entry_waddr),
        .wdata (entry_wdata),
        .re    (entry_re),
        .raddr (entry_raddr),
        .rdata (entry_rdata)
    );

    assign {rd_key, rd_value, rd_link_valid, rd_link} = entry_rdata;
    assign {head_valid, head_ptr} = head_rdata;
    assign new_idx   = PTR_W'(used_reg);
    assign pool_full = (used_reg == CNT_W'(POOL_ENTRIES));
    assign key_byte  = key_reg[8*hash_cnt_reg +: 8];

    always_comb begin
        reduce_r = bucket_reg;
        reduce_t = '0;
        for (int i = 7; i >= 0; i--) begin
            reduce_t = {reduce_r, key_byte[i]};
            if (reduce_t >= (BKT_W+1)'(BUCKETS)) begin
                reduce_t = reduce_t - (BKT_W+1)'(BUCKETS);
            end
            reduce_r = reduce_t[BKT_W-1:0];
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_RESULT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        used_next     = used_reg;
        hash_cnt_next = hash_cnt_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        bucket_next   = bucket_reg;
        cur_next      = cur_reg;
        status_next   = status_reg;
        rv_next       = rv_reg;
        m_valid_next  = m_valid_reg;

        head_we     = 1'b0;
        head_waddr  = bucket_reg;
        head_wdata  = {1'b1, new_idx};
        head_re     = 1'b0;
        head_raddr  = bucket_reg;
        entry_we    = 1'b0;
        entry_waddr = new_idx;
        entry_wdata = {key_reg, value_reg, 1'b0, PTR_W'(0)};
        entry_re    = 1'b0;
        entry_raddr = rd_link;

        resolve     = 1'b0;
        found       = 1'b0;
        chain_empty = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_idx_reg;
                head_wdata = '0;
                clr_idx_next = clr_idx_reg + BKT_W'(1);
                if (clr_idx_reg == BKT_W'(BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next      = s_command;
                    key_next      = s_key;
                    value_next    = s_value;
                    hash_cnt_next = 3'd7;
                    if (BUCKET_POW2) begin
                        bucket_next = s_key[BKT_W-1:0] & BKT_W'(BUCKETS - 1);
                        state_next  = S_HEAD;
                    end else begin
                        bucket_next = '0;
                        state_next  = S_HASH;
                    end
                end
            end
            S_HASH: begin
                bucket_next   = reduce_r;
                hash_cnt_next = hash_cnt_reg - 3'd1;
                if (hash_cnt_reg == 3'd0) begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                head_re    = 1'b1;
                state_next = S_HEADCHK;
            end
            S_HEADCHK: begin
                if (head_valid) begin
                    entry_re    = 1'b1;
                    entry_raddr = head_ptr;
                    cur_next    = head_ptr;
                    state_next  = S_WALK;
                end else begin
                    resolve     = 1'b1;
                    chain_empty = 1'b1;
                end
            end
            S_WALK: begin
                if (rd_key == key_reg) begin
                    resolve = 1'b1;
                    found   = 1'b1;
                end else if (rd_link_valid) begin
                    entry_re    = 1'b1;
                    entry_raddr = rd_link;
                    cur_next    = rd_link;
                end else begin
                    resolve = 1'b1;
                end
            end
            S_LINK: begin
                entry_we    = 1'b1;
                entry_waddr = new_idx;
                entry_wdata = {key_reg, value_reg, 1'b0, PTR_W'(0)};
                used_next   = used_reg + CNT_W'(1);
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (resolve) begin
            rv_next    = '0;
            state_next = S_RESULT;
            if (cmd_reg == CMD_GET) begin
                if (found) begin
                    rv_next     = rd_value;
                    status_next = ST_FOUND;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end else if (found) begin
                entry_we    = 1'b1;
                entry_waddr = cur_reg;
                entry_wdata = {rd_key, value_reg, rd_link_valid, rd_link};
                status_next = ST_UPDATED;
            end else if (pool_full) begin
                status_next = ST_POOL_FULL;
            end else if (chain_empty) begin
                head_we     = 1'b1;
                head_waddr  = bucket_reg;
                head_wdata  = {1'b1, new_idx};
                entry_we    = 1'b1;
                entry_waddr = new_idx;
                entry_wdata = {key_reg, value_reg, 1'b0, PTR_W'(0)};
                used_next   = used_reg + CNT_W'(1);
                status_next = ST_INSERTED;
            end else begin
                entry_we    = 1'b1;
                entry_waddr = cur_reg;
                entry_wdata = {rd_key, rd_value, 1'b1, new_idx};
                status_next = ST_INSERTED;
                state_next  = S_LINK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            used_reg     <= '0;
            hash_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            used_reg     <= used_next;
            hash_cnt_reg <= hash_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        bucket_reg <= bucket_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
        if (out_load) begin
            m_status_reg      <= status_reg;
            m_read_value_reg  <= rv_reg;
            m_entry_count_reg <= COUNT_W'(used_reg);
            m_is_empty_reg    <= (used_reg == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_is_empty    = m_is_empty_reg;

endmodule

[hdl/chm_checker.sv]
// ----------------------------------------------------------------------------
// Chained hash map checker
// Port-level assertions on the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_map_macros.svh"

module chm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [chm_pkg::STATUS_W-1:0]  m_status,
    input logic [chm_pkg::VALUE_W-1:0]   m_read_value,
    input logic [chm_pkg::COUNT_W-1:0]   m_entry_count,
    input logic                          m_is_empty
);

    import chm_pkg::*;

    logic in_fire;

    assign in_fire = s_valid && s_ready;

    // A result that reports an empty map must carry a zero entry count.
    `CHM_ASSERT_IMP(a_empty_matches_count, aclk, aresetn, m_valid, m_is_empty == (m_entry_count == '0))

    // Only a found key returns a nonzero value.
    `CHM_ASSERT_IMP(a_value_only_when_found, aclk, aresetn, m_valid && (m_status != ST_FOUND), m_read_value == '0)

    // An insert always leaves at least one key stored.
    `CHM_ASSERT_IMP(a_insert_not_empty, aclk, aresetn, m_valid && (m_status == ST_INSERTED), !m_is_empty)

    // A request accepted now cannot produce its result in the next cycle.
    `CHM_ASSERT_NXT(a_no_instant_result, aclk, aresetn, in_fire && !m_valid, !m_valid)

endmodule

bind chained_hash_map chm_checker u_chm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_read_value  (m_read_value),
    .m_entry_count (m_entry_count),
    .m_is_empty    (m_is_empty)
);
